// ===== sv/s20_pkg.sv =====
// Shared types, constants and index tables for the Salsa20 stream cipher block.
package s20_pkg;

    // Round count and the derived mix schedule
    localparam int unsigned ROUNDS        = 20;
    localparam int unsigned DOUBLE_ROUNDS = ROUNDS / 2;
    // one quarter-round line per cycle: 4 lines x 2 half rounds per double round
    localparam int unsigned MIX_STEPS     = DOUBLE_ROUNDS * 8;
    localparam int unsigned STEP_W        = $clog2(MIX_STEPS);

    localparam int unsigned POS_W     = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CTR   = 3'd5;

    // "expand 32-byte k" constant words
    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    // State word index per quarter round and role (a,b,c,d), nibble {q,role}
    localparam logic [63:0] COL_TAB = 64'hB73F_62EA_1D95_C840;
    localparam logic [63:0] ROW_TAB = 64'hEDCF_98BA_4765_3210;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic             load;    // build the initial state from key, nonce, counter
        logic             mix;     // apply one quarter-round line to all four columns/rows
        logic [2:0]       phase;   // [2] row half, [1:0] line within the quarter round
        logic             finish;  // add input words back, bump the block counter
        logic [POS_W-1:0] pos;     // keystream byte to present
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [7:0] ks_byte;
    } t_dp_sts;

    function automatic logic [3:0] qr_idx(input logic row, input logic [1:0] q,
                                          input logic [1:0] role);
        logic [5:0] base;
        base = {q, role, 2'b00};
        return row ? ROW_TAB[base +: 4] : COL_TAB[base +: 4];
    endfunction

endpackage

// ===== sv/s20_dp.sv =====
// Datapath: configuration, block counter, 16-word Salsa20 state and keystream byte select.
module s20_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [s20_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [s20_pkg::CFG_W-1:0]     i_cfg_data,
    input  s20_pkg::t_dp_cmd              i_cmd,
    output s20_pkg::t_dp_sts              o_sts
);

    logic [63:0] r_key [4];
    logic [63:0] r_nonce;
    logic [63:0] r_ctr;
    logic [31:0] r_w [16];
    logic [31:0] n_w [16];
    logic [31:0] init_w [16];

    logic [31:0] op1 [4];
    logic [31:0] op2 [4];
    logic [31:0] tv  [4];
    logic [31:0] sum [4];
    logic [31:0] rot [4];

    // Configuration registers and running block counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
            r_nonce <= '0;
            r_ctr   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    s20_pkg::CFG_KEY0:  r_key[0] <= i_cfg_data;
                    s20_pkg::CFG_KEY1:  r_key[1] <= i_cfg_data;
                    s20_pkg::CFG_KEY2:  r_key[2] <= i_cfg_data;
                    s20_pkg::CFG_KEY3:  r_key[3] <= i_cfg_data;
                    s20_pkg::CFG_NONCE: r_nonce  <= i_cfg_data;
                    s20_pkg::CFG_CTR:   r_ctr    <= i_cfg_data;
                    default: ;
                endcase
            end else if (i_cmd.finish) begin
                r_ctr <= r_ctr + 64'd1;
            end
        end
    end

    // Initial state words
    always_comb begin
        init_w[0]  = s20_pkg::SIGMA0;
        init_w[1]  = r_key[0][31:0];
        init_w[2]  = r_key[0][63:32];
        init_w[3]  = r_key[1][31:0];
        init_w[4]  = r_key[1][63:32];
        init_w[5]  = s20_pkg::SIGMA1;
        init_w[6]  = r_ctr[31:0];
        init_w[7]  = r_ctr[63:32];
        init_w[8]  = r_nonce[31:0];
        init_w[9]  = r_nonce[63:32];
        init_w[10] = s20_pkg::SIGMA2;
        init_w[11] = r_key[2][31:0];
        init_w[12] = r_key[2][63:32];
        init_w[13] = r_key[3][31:0];
        init_w[14] = r_key[3][63:32];
        init_w[15] = s20_pkg::SIGMA3;
    end

    // Operand select for the four parallel quarter rounds.
    // Line k: word[role k+1] ^= rotl(word[role k] + word[role k-1], R[k])
    always_comb begin
        for (int q = 0; q < 4; q++) begin
            op1[q] = '0;
            op2[q] = '0;
            tv[q]  = '0;
            for (int p = 0; p < 8; p++) begin
                if (i_cmd.phase == 3'(p)) begin
                    op1[q] = r_w[s20_pkg::qr_idx(p[2], 2'(q), 2'(p))];
                    op2[q] = r_w[s20_pkg::qr_idx(p[2], 2'(q), 2'(p + 3))];
                    tv[q]  = r_w[s20_pkg::qr_idx(p[2], 2'(q), 2'(p + 1))];
                end
            end
            sum[q] = op1[q] + op2[q];
            unique case (i_cmd.phase[1:0])
                2'd0:    rot[q] = {sum[q][24:0], sum[q][31:25]};
                2'd1:    rot[q] = {sum[q][22:0], sum[q][31:23]};
                2'd2:    rot[q] = {sum[q][18:0], sum[q][31:19]};
                default: rot[q] = {sum[q][13:0], sum[q][31:14]};
            endcase
        end
    end

    // Next state words
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_w[i] = r_w[i];
        end
        priority if (i_cmd.load) begin
            for (int i = 0; i < 16; i++) begin
                n_w[i] = init_w[i];
            end
        end else if (i_cmd.mix) begin
            for (int q = 0; q < 4; q++) begin
                for (int p = 0; p < 8; p++) begin
                    if (i_cmd.phase == 3'(p)) begin
                        n_w[s20_pkg::qr_idx(p[2], 2'(q), 2'(p + 1))] = tv[q] ^ rot[q];
                    end
                end
            end
        end else if (i_cmd.finish) begin
            for (int i = 0; i < 16; i++) begin
                n_w[i] = r_w[i] + init_w[i];
            end
        end
    end

    // State words; after the final add they hold the keystream block
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) begin
            r_w[i] <= n_w[i];
        end
    end

    assign o_sts.ks_byte = r_w[i_cmd.pos[5:2]][{i_cmd.pos[1:0], 3'b000} +: 8];

endmodule

// ===== sv/s20_ctrl.sv =====
// Controller: input/output handshakes, byte position, block build sequencing, output register.
module s20_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  s20_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output s20_pkg::t_out_item  o_out_item,
    output s20_pkg::t_dp_cmd    o_cmd,
    input  s20_pkg::t_dp_sts    i_sts
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MIX  = 4'b0010,
        S_ADD  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic [s20_pkg::STEP_W-1:0]    r_step, n_step;
    logic [s20_pkg::POS_W-1:0]     r_pos, n_pos;
    s20_pkg::t_in_item             r_hold;
    s20_pkg::t_out_item            r_out;
    logic                          r_oval;

    logic              slot_free;
    logic              accept;
    logic              emit;
    s20_pkg::t_in_item cur_item;

    assign slot_free  = !r_oval || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && slot_free;
    assign accept     = i_in_valid && o_in_ready;

    // Emit directly on accept when a block is ready, else after the build
    assign emit = (accept && (r_pos != '0)) || ((r_state == S_EMIT) && slot_free);
    assign cur_item = (r_state == S_EMIT) ? r_hold : i_in_item;

    // Datapath commands
    always_comb begin
        o_cmd.load   = accept && (r_pos == '0);
        o_cmd.mix    = (r_state == S_MIX);
        o_cmd.phase  = r_step[2:0];
        o_cmd.finish = (r_state == S_ADD);
        o_cmd.pos    = r_pos;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (r_pos == '0)) begin
                    n_state = S_MIX;
                    n_step  = '0;
                end
            end
            S_MIX: begin
                n_step = r_step + 1'b1;
                if (r_step == s20_pkg::STEP_W'(s20_pkg::MIX_STEPS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Byte position: wraps after 64 bytes, cleared after a last byte
    always_comb begin
        n_pos = r_pos;
        if (emit) begin
            n_pos = cur_item.last_byte ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_pos   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pos   <= n_pos;
            if (emit) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // Held item and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold <= i_in_item;
        end
        if (emit) begin
            r_out.out_byte <= cur_item.data_byte ^ i_sts.ks_byte;
            r_out.out_last <= cur_item.last_byte;
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_item  = r_out;

endmodule

// ===== sv/salsa20_stream_cipher.sv =====
// Top level of the Salsa20 byte stream cipher: controller, datapath and checks.
//
//  channel   | signals                                  | payload
//  ----------+------------------------------------------+---------------------------
//  input     | i_in_valid / o_in_ready                  | i_in_item  (data, last)
//  output    | o_out_valid / i_out_ready                | o_out_item (byte, last)
//  config    | i_cfg_we, i_cfg_idx                      | i_cfg_data (64 bits)
//
// A byte at a nonzero position is emitted straight on accept. A byte at position zero first builds a
// block: a load, MIX_STEPS (80) quarter-round line steps on the four-lane mixer,
// a feed-forward add and an emit.
// Synchronous active-low reset clears key, nonce, counter, position and handshakes.
// The output register lets a new item enter while a result waits; the block stalls
// input only when that register is full and not being drained, or during a build.
module salsa20_stream_cipher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [s20_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [s20_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  s20_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output s20_pkg::t_out_item            o_out_item
);

    s20_pkg::t_dp_cmd cmd;
    s20_pkg::t_dp_sts sts;

    s20_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    s20_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

    // Input is only taken when the output register can take the result
    a_ready_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid || i_out_ready))
        else $error("input ready while output register is blocked");

    // A block build starts only on an accepted item
    a_load_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (i_in_valid && o_in_ready))
        else $error("block load without an accepted item");

    // No item enters while the state is being mixed
    a_mix_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mix |-> !o_in_ready)
        else $error("input ready during block build");

    // The feed-forward add is followed by the emit, not more mixing
    a_finish_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> (!cmd.mix && !cmd.finish))
        else $error("mixing continued after feed-forward add");

endmodule

// ===== tb/salsa20_stream_cipher_tb.sv =====
// Self-checking testbench for the Salsa20 byte stream cipher: directed table plus random buffers.
module salsa20_stream_cipher_tb;

    // Index values past the register map, which the block must ignore
    localparam logic [s20_pkg::CFG_IDX_W-1:0] CFG_UNUSED6 = 3'd6;
    localparam logic [s20_pkg::CFG_IDX_W-1:0] CFG_UNUSED7 = 3'd7;
    localparam logic [s20_pkg::CFG_IDX_W-1:0] REG_ORDER [6] = '{
        s20_pkg::CFG_KEY0, s20_pkg::CFG_KEY1, s20_pkg::CFG_KEY2, s20_pkg::CFG_KEY3,
        s20_pkg::CFG_NONCE, s20_pkg::CFG_CTR
    };

    localparam int RAND_PHASES    = 10;
    localparam int PHASE_ITEMS    = 175;
    localparam int SETTLE_CYCLES  = 90;   // a bit more than one block build

    typedef enum logic {ROW_BYTE, ROW_REG} t_row_kind;
    typedef enum logic [1:0] {RUN_BUFFER, RUN_OPEN, RUN_NOISE} t_run_kind;
    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_MASK, STALL_HEAVY} t_stall_mode;

    typedef struct packed {
        t_row_kind                     kind;
        logic [s20_pkg::CFG_IDX_W-1:0] idx;    // register rows only
        logic [s20_pkg::CFG_W-1:0]     value;  // register rows only
        s20_pkg::t_in_item             item;   // byte rows only
    } t_row;

    // Directed sequence. No keystream byte can be read off directly, so every
    // byte row is checked against the predictor.
    localparam int DIR_ROWS = 27;
    localparam t_row DIRECTED_ROWS [DIR_ROWS] = '{
        // zero key and nonce right after reset
        '{ROW_BYTE, '0, 64'd0, '{8'h00, 1'b0}},
        '{ROW_BYTE, '0, 64'd0, '{8'hFF, 1'b0}},
        '{ROW_BYTE, '0, 64'd0, '{8'h5A, 1'b1}},
        '{ROW_BYTE, '0, 64'd0, '{8'hFF, 1'b1}},
        // all-ones key material but key word 2, counter at its top value
        '{ROW_REG, s20_pkg::CFG_KEY0,  64'hFFFF_FFFF_FFFF_FFFF, '{8'h00, 1'b0}},
        '{ROW_REG, s20_pkg::CFG_KEY1,  64'hFFFF_FFFF_FFFF_FFFF, '{8'h00, 1'b0}},
        '{ROW_REG, s20_pkg::CFG_KEY2,  64'h0123_4567_89AB_CDEF, '{8'h00, 1'b0}},
        '{ROW_REG, s20_pkg::CFG_KEY3,  64'hFFFF_FFFF_FFFF_FFFF, '{8'h00, 1'b0}},
        '{ROW_REG, s20_pkg::CFG_NONCE, 64'hFFFF_FFFF_FFFF_FFFF, '{8'h00, 1'b0}},
        '{ROW_REG, s20_pkg::CFG_CTR,   64'hFFFF_FFFF_FFFF_FFFF, '{8'h00, 1'b0}},
        // block at counter max, then the wrapped block at zero
        '{ROW_BYTE, '0, 64'd0, '{8'h00, 1'b0}},
        '{ROW_BYTE, '0, 64'd0, '{8'hA5, 1'b1}},
        '{ROW_BYTE, '0, 64'd0, '{8'hFF, 1'b1}},
        // counter rewritten mid-buffer: current block stays in use
        '{ROW_BYTE, '0, 64'd0, '{8'h11, 1'b0}},
        '{ROW_BYTE, '0, 64'd0, '{8'h22, 1'b0}},
        '{ROW_REG, s20_pkg::CFG_CTR,   64'h0000_0000_FFFF_FFFF, '{8'h00, 1'b0}},
        '{ROW_BYTE, '0, 64'd0, '{8'h33, 1'b0}},
        '{ROW_BYTE, '0, 64'd0, '{8'h44, 1'b1}},
        // new counter picked up here, low half carries into high half
        '{ROW_BYTE, '0, 64'd0, '{8'h80, 1'b1}},
        // writes past the register map change nothing
        '{ROW_REG, CFG_UNUSED6, 64'hDEAD_BEEF_CAFE_F00D, '{8'h00, 1'b0}},
        '{ROW_REG, CFG_UNUSED7, 64'hFFFF_FFFF_FFFF_FFFF, '{8'h00, 1'b0}},
        '{ROW_BYTE, '0, 64'd0, '{8'h01, 1'b1}},
        '{ROW_REG, s20_pkg::CFG_KEY0,  64'h0000_0000_0000_0000, '{8'h00, 1'b0}},
        '{ROW_REG, s20_pkg::CFG_KEY3,  64'h8000_0000_0000_0000, '{8'h00, 1'b0}},
        '{ROW_REG, s20_pkg::CFG_NONCE, 64'h0000_0000_0000_0000, '{8'h00, 1'b0}},
        '{ROW_BYTE, '0, 64'd0, '{8'h7F, 1'b0}},
        '{ROW_BYTE, '0, 64'd0, '{8'hFE, 1'b1}}
    };

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_cfg_we   = 1'b0;
    logic [s20_pkg::CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [s20_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    s20_pkg::t_in_item             i_in_item  = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    s20_pkg::t_out_item            o_out_item;

    // Predictor state
    logic [63:0]               key_reg [4] = '{default: '0};
    logic [63:0]               nonce_reg   = '0;
    logic [63:0]               ctr_next    = '0;
    logic [7:0]                ks_bytes [64];
    logic [s20_pkg::POS_W-1:0] ks_pos      = '0;
    logic [31:0]               mix_w [16];

    s20_pkg::t_out_item cipher_expect [$];
    int                 error_count = 0;
    int                 burst_left  = 0;
    int                 stall_left  = 0;
    t_stall_mode        stall_mode  = STALL_NONE;
    logic [31:0]        stall_mask  = '1;

    salsa20_stream_cipher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void mix_quarter(input int a, input int b, input int c, input int d);
        mix_w[b] ^= rotl32(mix_w[a] + mix_w[d], 7);
        mix_w[c] ^= rotl32(mix_w[b] + mix_w[a], 9);
        mix_w[d] ^= rotl32(mix_w[c] + mix_w[b], 13);
        mix_w[a] ^= rotl32(mix_w[d] + mix_w[c], 18);
    endfunction

    // Fresh 64-byte keystream block from key, nonce and running counter
    function automatic void build_keystream();
        logic [31:0] seed [16];
        logic [31:0] sum;
        seed[0]  = s20_pkg::SIGMA0;
        seed[5]  = s20_pkg::SIGMA1;
        seed[10] = s20_pkg::SIGMA2;
        seed[15] = s20_pkg::SIGMA3;
        seed[1]  = key_reg[0][31:0];
        seed[2]  = key_reg[0][63:32];
        seed[3]  = key_reg[1][31:0];
        seed[4]  = key_reg[1][63:32];
        seed[11] = key_reg[2][31:0];
        seed[12] = key_reg[2][63:32];
        seed[13] = key_reg[3][31:0];
        seed[14] = key_reg[3][63:32];
        seed[6]  = ctr_next[31:0];
        seed[7]  = ctr_next[63:32];
        seed[8]  = nonce_reg[31:0];
        seed[9]  = nonce_reg[63:32];
        mix_w = seed;
        // odd round counts round down to whole double rounds
        for (int r = 0; r < s20_pkg::ROUNDS / 2; r++) begin
            mix_quarter(0, 4, 8, 12);
            mix_quarter(5, 9, 13, 1);
            mix_quarter(10, 14, 2, 6);
            mix_quarter(15, 3, 7, 11);
            mix_quarter(0, 1, 2, 3);
            mix_quarter(5, 6, 7, 4);
            mix_quarter(10, 11, 8, 9);
            mix_quarter(15, 12, 13, 14);
        end
        for (int i = 0; i < 16; i++) begin
            sum = mix_w[i] + seed[i];
            for (int b = 0; b < 4; b++) begin
                ks_bytes[4 * i + b] = sum[8 * b +: 8];
            end
        end
        ctr_next += 64'd1;  // wraps at 2^64
    endfunction

    function automatic s20_pkg::t_out_item encrypt_byte(input s20_pkg::t_in_item it);
        s20_pkg::t_out_item res;
        if (ks_pos == '0) begin
            build_keystream();
        end
        res.out_byte = it.data_byte ^ ks_bytes[ks_pos];
        res.out_last = it.last_byte;
        ks_pos = (it.last_byte || ks_pos == '1) ? '0 : ks_pos + 1'b1;
        return res;
    endfunction

    function automatic void report_mismatch(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    // Sender: bursts of random length, random gaps between them
    task automatic push_byte(input s20_pkg::t_in_item it);
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        cipher_expect.push_back(encrypt_byte(it));
    endtask

    // Drop valid and let every outstanding result drain
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (cipher_expect.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [s20_pkg::CFG_IDX_W-1:0] idx,
                             input logic [s20_pkg::CFG_W-1:0] val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            s20_pkg::CFG_KEY0:  key_reg[0] = val;
            s20_pkg::CFG_KEY1:  key_reg[1] = val;
            s20_pkg::CFG_KEY2:  key_reg[2] = val;
            s20_pkg::CFG_KEY3:  key_reg[3] = val;
            s20_pkg::CFG_NONCE: nonce_reg  = val;
            s20_pkg::CFG_CTR:   ctr_next   = val;  // byte position is left alone
            default: ;
        endcase
    endtask

    // Register values biased toward the extremes and the counter wrap
    function automatic logic [s20_pkg::CFG_W-1:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 2);
            3:       return 64'h0000_0000_FFFF_FFFF;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic send_run(input int len, input t_run_kind kind);
        s20_pkg::t_in_item it;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0:       it.data_byte = 8'h00;
                1:       it.data_byte = 8'hFF;
                default: it.data_byte = 8'($urandom());
            endcase
            case (kind)
                RUN_BUFFER: it.last_byte = (k == len - 1);
                RUN_NOISE:  it.last_byte = 1'($urandom_range(0, 1));
                default:    it.last_byte = 1'b0;
            endcase
            push_byte(it);
        end
    endtask

    // Receiver stall pattern, with a new mode and mask picked when the current stretch runs out
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(16, 96);
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_mask = $urandom();
        end
        stall_left--;
        stall_mask = {stall_mask[0], stall_mask[31:1]};
        case (stall_mode)
            STALL_NONE: i_out_ready <= 1'b1;
            STALL_COIN: i_out_ready <= 1'($urandom_range(0, 1));
            STALL_MASK: i_out_ready <= stall_mask[0];
            default:    i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cipher_expect.size() == 0) begin
                report_mismatch($sformatf("unexpected item byte=%h last=%b",
                                          o_out_item.out_byte, o_out_item.out_last));
            end else begin
                if (o_out_item.out_byte !== cipher_expect[0].out_byte) begin
                    report_mismatch($sformatf("out_byte: expected %h, got %h",
                                              cipher_expect[0].out_byte, o_out_item.out_byte));
                end
                if (o_out_item.out_last !== cipher_expect[0].out_last) begin
                    report_mismatch($sformatf("out_last: expected %b, got %b",
                                              cipher_expect[0].out_last, o_out_item.out_last));
                end
                void'(cipher_expect.pop_front());
            end
        end
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_row      row;
        int        sent;
        int        sel;
        int        len;
        t_run_kind kind;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_REG) begin
                write_reg(row.idx, row.value);
            end else begin
                push_byte(row.item);
            end
        end

        // Random phases: even phases rewrite every register, odd phases a random subset
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            foreach (REG_ORDER[r]) begin
                if (ph % 2 == 0 || $urandom_range(0, 1) == 1) begin
                    write_reg(REG_ORDER[r], pick_reg_value());
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_UNUSED6 : CFG_UNUSED7,
                          {$urandom(), $urandom()});
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    len  = $urandom_range(1, 12);
                    kind = RUN_BUFFER;
                end else if (sel < 82) begin
                    // long buffer, which can cross up to three block boundaries
                    len  = $urandom_range(60, 140);
                    kind = RUN_BUFFER;
                end else if (sel < 92) begin
                    len  = $urandom_range(1, 16);
                    kind = RUN_NOISE;
                end else begin
                    // unterminated run, so the next setting lands mid-buffer
                    len  = $urandom_range(1, 20);
                    kind = RUN_OPEN;
                end
                // the last run of a phase is cut to the item budget
                if (len > PHASE_ITEMS - sent) begin
                    len = PHASE_ITEMS - sent;
                end
                send_run(len, kind);
                sent += len;
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && cipher_expect.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/s20_pkg.sv
sv/s20_dp.sv
sv/s20_ctrl.sv
sv/salsa20_stream_cipher.sv
tb/salsa20_stream_cipher_tb.sv
